### src/tbcd_pkg.sv
// Package for the two-button chord decoder.
// Holds shared codes, register indexes, widths and the queue entry type.
// No dependencies.
package tbcd_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd200;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd300;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    typedef enum logic [1:0] {
        CODE_FIRST  = 2'd1,
        CODE_SECOND = 2'd2,
        CODE_STOP   = 2'd3
    } code_t;

    // One queued request: one or two codes from a single sample
    typedef struct packed {
        logic  two_codes;
        code_t code0;
        code_t code1;
    } job_t;

endpackage

### src/tbcd_front.sv
// Front part of the chord decoder: configuration registers, button state
// and classification of each sample into zero, one or two codes.
// Depends on tbcd_pkg.
module tbcd_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbcd_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            in_accept,
    input  logic [tbcd_pkg::TIME_W-1:0]     time_ms,
    input  logic                            first_held,
    input  logic                            second_held,
    input  logic                            link_up,
    output logic                            job_valid,
    output tbcd_pkg::job_t                  job
);

    logic [tbcd_pkg::CFG_W-1:0]  debounce_reg, window_reg, hold_reg;
    logic [tbcd_pkg::TIME_W-1:0] first_time_reg, first_time_next;
    logic [tbcd_pkg::TIME_W-1:0] second_time_reg, second_time_next;
    logic first_down_reg, first_down_next;
    logic second_down_reg, second_down_next;
    logic chord_done_reg, chord_done_next;
    logic first_used_reg, first_used_next;
    logic second_used_reg, second_used_next;

    logic [tbcd_pkg::TIME_W-1:0] lo_time, hi_time;
    logic stop_hit, tap_first, tap_second;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= tbcd_pkg::DEBOUNCE_RST;
            window_reg   <= tbcd_pkg::WINDOW_RST;
            hold_reg     <= tbcd_pkg::HOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tbcd_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                tbcd_pkg::CFG_WINDOW:   window_reg   <= cfg_wdata;
                tbcd_pkg::CFG_HOLD:     hold_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Press, chord and release evaluation, in the order of priority
    always_comb begin
        first_time_next  = first_time_reg;
        second_time_next = second_time_reg;
        first_down_next  = first_down_reg;
        second_down_next = second_down_reg;
        chord_done_next  = chord_done_reg;
        first_used_next  = first_used_reg;
        second_used_next = second_used_reg;
        stop_hit   = 1'b0;
        tap_first  = 1'b0;
        tap_second = 1'b0;
        lo_time    = '0;
        hi_time    = '0;

        // debounced presses (wrapping time difference)
        if (first_held && !first_down_reg &&
            (time_ms - first_time_reg) > tbcd_pkg::TIME_W'(debounce_reg)) begin
            first_down_next = 1'b1;
            first_used_next = 1'b0;
            first_time_next = time_ms;
        end
        if (second_held && !second_down_reg &&
            (time_ms - second_time_reg) > tbcd_pkg::TIME_W'(debounce_reg)) begin
            second_down_next = 1'b1;
            second_used_next = 1'b0;
            second_time_next = time_ms;
        end

        // chord: both down, presses close together, held long enough
        if (first_down_next && second_down_next && !chord_done_reg) begin
            if (first_time_next < second_time_next) begin
                lo_time = first_time_next;
                hi_time = second_time_next;
            end else begin
                lo_time = second_time_next;
                hi_time = first_time_next;
            end
            if ((hi_time - lo_time) < tbcd_pkg::TIME_W'(window_reg) &&
                (time_ms - lo_time) >= tbcd_pkg::TIME_W'(hold_reg)) begin
                stop_hit         = link_up;
                chord_done_next  = 1'b1;
                first_used_next  = 1'b1;
                second_used_next = 1'b1;
            end
        end

        // first button release
        if (!first_held && first_down_next) begin
            first_down_next = 1'b0;
            tap_first       = !first_used_next && !chord_done_next && link_up;
            first_used_next = 1'b0;
            if (!second_held && !second_down_next) begin
                chord_done_next = 1'b0;
            end
        end

        // second button release
        if (!second_held && second_down_next) begin
            second_down_next = 1'b0;
            tap_second       = !second_used_next && !chord_done_next && link_up;
            second_used_next = 1'b0;
            if (!first_held && !first_down_next) begin
                chord_done_next = 1'b0;
            end
        end

        if (!first_held && !second_held) begin
            chord_done_next = 1'b0;
        end
    end

    // Build the queue request; stop and taps never meet in one sample
    always_comb begin
        job_valid     = in_accept && (stop_hit || tap_first || tap_second);
        job.two_codes = tap_first && tap_second;
        job.code1     = tbcd_pkg::CODE_SECOND;
        if (stop_hit) begin
            job.code0 = tbcd_pkg::CODE_STOP;
        end else if (tap_first) begin
            job.code0 = tbcd_pkg::CODE_FIRST;
        end else begin
            job.code0 = tbcd_pkg::CODE_SECOND;
        end
    end

    // Button state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_time_reg  <= '0;
            second_time_reg <= '0;
            first_down_reg  <= 1'b0;
            second_down_reg <= 1'b0;
            chord_done_reg  <= 1'b0;
            first_used_reg  <= 1'b0;
            second_used_reg <= 1'b0;
        end else if (in_accept) begin
            first_time_reg  <= first_time_next;
            second_time_reg <= second_time_next;
            first_down_reg  <= first_down_next;
            second_down_reg <= second_down_next;
            chord_done_reg  <= chord_done_next;
            first_used_reg  <= first_used_next;
            second_used_reg <= second_used_next;
        end
    end

    // A stop code never shares a request with a tap
    a_stop_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job.code0 == tbcd_pkg::CODE_STOP |-> !job.two_codes)
        else $error("stop code queued together with a tap");

endmodule

### src/tbcd_queue.sv
// Short request queue between the front and back parts of the decoder.
// Flip-flop storage of tbcd_pkg::QUEUE_DEPTH entries.
// Depends on tbcd_pkg.
module tbcd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tbcd_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tbcd_pkg::job_t head_job
);

    tbcd_pkg::job_t entry_reg [tbcd_pkg::QUEUE_DEPTH];
    logic [tbcd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tbcd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tbcd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == tbcd_pkg::QUEUE_CNT_W'(tbcd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == tbcd_pkg::QUEUE_PTR_W'(tbcd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tbcd_pkg::QUEUE_PTR_W'(tbcd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // A request must never arrive while the queue is full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("request pushed into full queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tbcd_pkg::QUEUE_CNT_W'(tbcd_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

### src/tbcd_back.sv
// Back part of the chord decoder: takes requests from the queue and sends
// their codes one per cycle, while m_tready allows, through an output register.
// Depends on tbcd_pkg.
module tbcd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  tbcd_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tbcd_pkg::code_t out_code,
    output logic           m_tlast
);

    logic            out_valid_reg, out_valid_next;
    tbcd_pkg::code_t out_code_reg, out_code_next;
    logic            out_last_reg, out_last_next;
    logic            pend_valid_reg, pend_valid_next;
    tbcd_pkg::code_t pend_code_reg, pend_code_next;
    logic            can_load;

    assign can_load = !out_valid_reg || m_tready;
    assign q_pop    = can_load && !pend_valid_reg && q_not_empty;

    assign m_tvalid = out_valid_reg;
    assign out_code = out_code_reg;
    assign m_tlast  = out_last_reg;

    // Output register load: pending second code first, then a new request
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        if (can_load) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_code_next   = pend_code_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end else if (q_not_empty) begin
                out_valid_next  = 1'b1;
                out_code_next   = q_job.code0;
                out_last_next   = !q_job.two_codes;
                pend_valid_next = q_job.two_codes;
                pend_code_next  = q_job.code1;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_code_reg  <= out_code_next;
        out_last_reg  <= out_last_next;
        pend_code_reg <= pend_code_next;
    end

    // A held second code always sits behind a shown first code
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg && !out_last_reg)
        else $error("second code pending without first code shown");

    // A non-final code is always followed by its pending partner
    a_not_last_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> pend_valid_reg)
        else $error("non-final code without a pending second code");

endmodule

### src/two_button_chord_decoder.sv
// Top level of the two-button chord decoder.
// Instantiates tbcd_front, tbcd_queue and tbcd_back; uses tbcd_pkg.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  time_ms, first_held, second_held, link_up
// m_        out        m_tvalid/m_tready  command_code, last_of_run (m_tlast)
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One sample is accepted per cycle while the two-entry request queue has room.
// A sample's codes pass through the request queue and the output register, one
// per cycle while m_tready allows; a sample with two codes holds the output
// register for both, so the sustained rate is set by the back part.
// A stalled m_ side fills the queue, then s_tready drops.
// aresetn is synchronous; it restores register defaults and clears button state, queue count and valid flags.
module two_button_chord_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbcd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] time_ms, [32] first_held, [33] second_held, [34] link_up, rest zero
    input  logic [tbcd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] command_code, rest zero
    output logic [tbcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    logic            in_accept;
    logic            job_valid;
    tbcd_pkg::job_t  job;
    logic            q_full, q_not_empty, q_pop;
    tbcd_pkg::job_t  q_job;
    tbcd_pkg::code_t out_code;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;
    assign m_tdata   = {{(tbcd_pkg::OUT_TDATA_W - 2){1'b0}}, out_code};

    tbcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_accept   (in_accept),
        .time_ms     (s_tdata[31:0]),
        .first_held  (s_tdata[32]),
        .second_held (s_tdata[33]),
        .link_up     (s_tdata[34]),
        .job_valid   (job_valid),
        .job         (job)
    );

    tbcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_job  (job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_job)
    );

    tbcd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_code    (out_code),
        .m_tlast     (m_tlast)
    );

endmodule

### bench/chord_code_checker.sv
// Checker for the two-button chord decoder: watches the register port and both
// streams, predicts the command codes of every accepted sample and compares.
// Depends on tbcd_pkg for widths, register indexes and the code enum.
module chord_code_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbcd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // [31:0] time_ms, [32] first_held, [33] second_held, [34] link_up, rest zero
    input  logic [tbcd_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] command_code, rest zero
    input  logic [tbcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tlast,
    output logic [31:0]                         fail_count,
    output logic [31:0]                         pending
);
    import tbcd_pkg::*;

    typedef struct packed {
        code_t code;
        logic  last;
    } code_due_t;

    // Codes still owed by the block, oldest first
    code_due_t codes_due [$];
    int mismatches;

    // Register copies
    logic [CFG_W-1:0] bounce_gap, window_ms, hold_ms;

    // Button tracking
    logic [TIME_W-1:0] first_at, second_at;
    logic first_dn, second_dn, stop_sent, first_used, second_used;

    // Advance the button tracking by one sample and queue the codes it owes
    task automatic decode_sample(input logic [TIME_W-1:0] now, input logic b1,
                                 input logic b2, input logic link);
        logic [TIME_W-1:0] since, lo, hi, gap, held;
        code_t found [0:1];
        int n;
        n = 0;

        // Debounced presses
        since = now - first_at;
        if (b1 && !first_dn && since > {16'd0, bounce_gap}) begin
            first_dn = 1'b1;
            first_used = 1'b0;
            first_at = now;
        end
        since = now - second_at;
        if (b2 && !second_dn && since > {16'd0, bounce_gap}) begin
            second_dn = 1'b1;
            second_used = 1'b0;
            second_at = now;
        end

        // Chord: gap is a plain difference, hold is taken modulo 2^32
        if (first_dn && second_dn && !stop_sent) begin
            lo = (first_at < second_at) ? first_at : second_at;
            hi = (first_at < second_at) ? second_at : first_at;
            gap = hi - lo;
            held = now - lo;
            if (gap < {16'd0, window_ms} && held >= {16'd0, hold_ms}) begin
                if (link) begin
                    found[n] = CODE_STOP;
                    n++;
                end
                stop_sent = 1'b1;
                first_used = 1'b1;
                second_used = 1'b1;
            end
        end

        // Releases; first button's code goes ahead of the second's
        if (!b1 && first_dn) begin
            first_dn = 1'b0;
            if (!first_used && !stop_sent && link) begin
                found[n] = CODE_FIRST;
                n++;
            end
            first_used = 1'b0;
            if (!b2 && !second_dn) stop_sent = 1'b0;
        end
        if (!b2 && second_dn) begin
            second_dn = 1'b0;
            if (!second_used && !stop_sent && link && n < 2) begin
                found[n] = CODE_SECOND;
                n++;
            end
            second_used = 1'b0;
            if (!b1 && !first_dn) stop_sent = 1'b0;
        end
        if (!b1 && !b2) stop_sent = 1'b0;

        for (int k = 0; k < n; k++) begin
            codes_due.push_back('{code: found[k], last: (k == n - 1)});
        end
    endtask

    // Compare one delivered code with the oldest one owed
    task automatic check_code();
        code_due_t want;
        if (codes_due.size() == 0) begin
            $error("unexpected result: command_code %0d, m_tlast %0b",
                   m_tdata[1:0], m_tlast);
            mismatches++;
        end else begin
            want = codes_due.pop_front();
            if (m_tdata[1:0] !== want.code) begin
                $error("command_code: expected %0d, got %0d", want.code, m_tdata[1:0]);
                mismatches++;
            end
            if (m_tlast !== want.last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                mismatches++;
            end
            if (m_tdata[OUT_TDATA_W-1:2] !== '0) begin
                $error("m_tdata padding: expected 0, got %0h", m_tdata[OUT_TDATA_W-1:2]);
                mismatches++;
            end
        end
    endtask

    // Output side first: a code leaving now never belongs to a sample taken now
    always @(posedge aclk) begin
        if (!aresetn) begin
            bounce_gap = DEBOUNCE_RST;
            window_ms = WINDOW_RST;
            hold_ms = HOLD_RST;
            first_at = '0;
            second_at = '0;
            first_dn = 1'b0;
            second_dn = 1'b0;
            stop_sent = 1'b0;
            first_used = 1'b0;
            second_used = 1'b0;
            codes_due.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) check_code();
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEBOUNCE: bounce_gap = cfg_wdata;
                    CFG_WINDOW:   window_ms = cfg_wdata;
                    CFG_HOLD:     hold_ms = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_sample(s_tdata[TIME_W-1:0], s_tdata[TIME_W], s_tdata[TIME_W+1],
                              s_tdata[TIME_W+2]);
            end
        end
        pending <= codes_due.size();
        fail_count <= mismatches;
    end

endmodule

### bench/tb_two_button_chord_decoder.sv
// Testbench top for the two-button chord decoder: clock, reset, register writes,
// sample stimulus and back-pressure; the verdict comes from chord_code_checker.
// Depends on tbcd_pkg, two_button_chord_decoder and chord_code_checker.
module tb_two_button_chord_decoder;
    import tbcd_pkg::*;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int PHASES = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       m_tlast;
    logic [31:0]                fail_count;
    logic [31:0]                pending;

    // Stimulus shaping state
    int debounce_cfg = int'(DEBOUNCE_RST);
    int window_cfg = int'(WINDOW_RST);
    int hold_cfg = int'(HOLD_RST);
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;
    logic [TIME_W-1:0] now_ms = '0;

    two_button_chord_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    chord_code_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int step_span();
        return hold_cfg / 4 + window_cfg / 8 + 5;
    endfunction

    // One sample request; optional idle cycles ahead of it, then wait for the handshake
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic first,
                               input logic second, input logic link);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - TIME_W - 3){1'b0}}, link, second, first, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Register write; the caller lowers cfg_wr_en after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        case (idx)
            CFG_DEBOUNCE: debounce_cfg = value;
            CFG_WINDOW:   window_cfg = value;
            CFG_HOLD:     hold_cfg = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_registers(input int debounce, input int window, input int hold);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_WINDOW, window);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_SPARE, $urandom_range(0, 65535));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Let every owed code come out, then give the block time to go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Single-button tap; sometimes too soon after the last press (bounce)
    task automatic tap_burst();
        logic pick_second, link;
        pick_second = 1'($urandom_range(1));
        link = ($urandom_range(99) < 90);
        if ($urandom_range(99) < 80) begin
            now_ms = now_ms + debounce_cfg + 1 + $urandom_range(0, step_span());
        end else begin
            now_ms = now_ms + $urandom_range(0, debounce_cfg);
        end
        repeat ($urandom_range(1, 3)) begin
            send_sample(now_ms, !pick_second, pick_second, link);
            now_ms = now_ms + $urandom_range(0, step_span());
        end
        send_sample(now_ms, 1'b0, 1'b0, link);
    endtask

    // Both buttons: press gap around the window, hold around the hold time
    task automatic chord_burst();
        logic link, lead_second, keep_second;
        logic [TIME_W-1:0] start, elapsed;
        int target;
        link = ($urandom_range(99) < 90);
        lead_second = 1'($urandom_range(1));
        now_ms = now_ms + debounce_cfg + 1 + $urandom_range(0, step_span());
        start = now_ms;
        if ($urandom_range(3) != 0) begin
            send_sample(now_ms, !lead_second, lead_second, link);
            now_ms = now_ms + $urandom_range(0, window_cfg + window_cfg / 8 + 2);
        end
        send_sample(now_ms, 1'b1, 1'b1, link);
        if ($urandom_range(2) == 0) begin
            target = $urandom_range(0, hold_cfg);
        end else begin
            target = hold_cfg + $urandom_range(0, hold_cfg / 8 + 2);
        end
        elapsed = now_ms - start;
        while (elapsed < target) begin
            now_ms = now_ms + $urandom_range(1, target / 3 + 1);
            send_sample(now_ms, 1'b1, 1'b1, link);
            elapsed = now_ms - start;
        end
        now_ms = now_ms + $urandom_range(0, step_span());
        if ($urandom_range(1)) begin
            send_sample(now_ms, 1'b0, 1'b0, link);
        end else begin
            keep_second = 1'($urandom_range(1));
            send_sample(now_ms, !keep_second, keep_second, link);
            now_ms = now_ms + $urandom_range(0, step_span());
            send_sample(now_ms, 1'b0, 1'b0, link);
        end
    endtask

    // Unstructured samples, with occasional jumps anywhere in the time range
    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) == 0) begin
                now_ms = $urandom;
            end else begin
                now_ms = now_ms + $urandom_range(0, step_span());
            end
            send_sample(now_ms, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        end
    endtask

    initial begin
        int pick;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            // Register setting for this phase; the first runs on reset values
            case (p)
                0: ;
                1: set_registers(0, 65535, 0);
                2: set_registers(65535, 0, 65535);
                4: set_registers(int'(DEBOUNCE_RST), int'(WINDOW_RST), int'(HOLD_RST));
                default: set_registers($urandom_range(0, 120), $urandom_range(0, 600),
                                       $urandom_range(0, 700));
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase

            if (p == 0) begin
                // Presses too soon after reset, at and just past the debounce edge
                send_sample(32'd0, 1'b1, 1'b0, 1'b1);
                send_sample(32'd10, 1'b0, 1'b0, 1'b1);
                send_sample(32'd50, 1'b1, 1'b0, 1'b1);
                send_sample(32'd60, 1'b0, 1'b0, 1'b1);
                send_sample(32'd100, 1'b1, 1'b0, 1'b1);
                send_sample(32'd110, 1'b0, 1'b0, 1'b1);
                // Second button tap
                send_sample(32'd200, 1'b0, 1'b1, 1'b1);
                send_sample(32'd210, 1'b0, 1'b0, 1'b1);
                // Tap with the link down
                send_sample(32'd300, 1'b1, 1'b0, 1'b0);
                send_sample(32'd310, 1'b0, 1'b0, 1'b0);
                // Chord held past the hold time, releases stay silent
                send_sample(32'd500, 1'b1, 1'b0, 1'b1);
                send_sample(32'd550, 1'b1, 1'b1, 1'b1);
                send_sample(32'd900, 1'b1, 1'b1, 1'b1);
                send_sample(32'd910, 1'b1, 1'b0, 1'b1);
                send_sample(32'd920, 1'b0, 1'b0, 1'b1);
                // Both released in one sample before the hold time: two codes
                send_sample(32'd1100, 1'b1, 1'b1, 1'b1);
                send_sample(32'd1110, 1'b0, 1'b0, 1'b1);
                // Press gap outside the window
                send_sample(32'd1300, 1'b1, 1'b0, 1'b1);
                send_sample(32'd1600, 1'b1, 1'b1, 1'b1);
                send_sample(32'd2000, 1'b1, 1'b1, 1'b1);
                send_sample(32'd2010, 1'b0, 1'b0, 1'b1);
                // Presses on both sides of the timestamp wrap
                send_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
                send_sample(32'h0000_0005, 1'b1, 1'b1, 1'b1);
                send_sample(32'h0000_0400, 1'b0, 1'b0, 1'b1);
                now_ms = 32'h0000_0400;
            end

            while (items_sent < (p + 1) * ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    tap_burst();
                end else if (pick < 75) begin
                    chord_burst();
                end else begin
                    noise_burst();
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/tbcd_pkg.sv
src/tbcd_front.sv
src/tbcd_queue.sv
src/tbcd_back.sv
src/two_button_chord_decoder.sv
bench/chord_code_checker.sv
bench/tb_two_button_chord_decoder.sv
